FILE: src/ptt_pkg.sv
package ptt_pkg;

   localparam int unsigned NumSlotsDefault = 16;

   localparam int unsigned TimeWidth    = 64;
   localparam int unsigned HandlerWidth = 16;
   localparam int unsigned WordWidth    = 32;
   localparam int unsigned SlotWidth    = 4;

   typedef enum logic [1:0] {
      OP_TICK = 2'd0,
      OP_ADD  = 2'd1,
      OP_DEL  = 2'd2,
      OP_NONE = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      RK_ADDED     = 3'd0,
      RK_FULL      = 3'd1,
      RK_DELETED   = 3'd2,
      RK_NOT_FOUND = 3'd3,
      RK_FIRED     = 3'd4,
      RK_DONE      = 3'd5
   } result_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_EMIT,
      ST_FINAL
   } state_type;

endpackage

FILE: src/ptt_req_if.sv
interface ptt_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [1:0]                           opcode;
   logic [ptt_pkg::TimeWidth-1:0]        now_time;
   logic [ptt_pkg::HandlerWidth-1:0]     handler_id;
   logic [ptt_pkg::WordWidth-1:0]        match_key;
   logic [ptt_pkg::WordWidth-1:0]        payload_a;
   logic [ptt_pkg::WordWidth-1:0]        payload_b;
   logic [ptt_pkg::WordWidth-1:0]        payload_c;
   logic [ptt_pkg::WordWidth-1:0]        period;
   logic                                 one_shot;

   modport source (output valid, opcode, now_time, handler_id, match_key, payload_a,
                   payload_b, payload_c, period, one_shot, input ready);
   modport sink (input valid, opcode, now_time, handler_id, match_key, payload_a,
                 payload_b, payload_c, period, one_shot, output ready);
endinterface

FILE: src/ptt_rsp_if.sv
interface ptt_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [2:0]                           result_kind;
   logic [ptt_pkg::SlotWidth-1:0]        slot_index;
   logic [ptt_pkg::HandlerWidth-1:0]     fired_handler;
   logic [ptt_pkg::WordWidth-1:0]        fired_key;
   logic [ptt_pkg::WordWidth-1:0]        fired_payload_a;
   logic [ptt_pkg::WordWidth-1:0]        fired_payload_b;
   logic [ptt_pkg::WordWidth-1:0]        fired_payload_c;
   logic                                 last;

   modport source (output valid, result_kind, slot_index, fired_handler, fired_key,
                   fired_payload_a, fired_payload_b, fired_payload_c, last, input ready);
   modport sink (input valid, result_kind, slot_index, fired_handler, fired_key,
                 fired_payload_a, fired_payload_b, fired_payload_c, last, output ready);
endinterface

FILE: src/periodic_timer_table.sv
// chan | dir | handshake   | beat
// req_ | in  | valid/ready | opcode, now_time, handler_id, match_key, payloads, period, one_shot
// rsp_ | out | valid/ready | result_kind, slot_index, fired_* words, last
//
// Add answers in the cycle after its beat is taken.
// A tick walks slot by slot: it reads each slot, evaluates each valid slot, emits a beat
// for each fired slot, then closes through the final state with a last beat.
// Delete walks the same way and stops at the first match.
// Reset clears valid bits and the controller; memory contents need no clearing.
// A stalled rsp_ beat holds the walk; req_ is taken only while idle with no beat pending.
module periodic_timer_table #(
   parameter int unsigned NUM_SLOTS = ptt_pkg::NumSlotsDefault
) (
   input  logic     clock,
   input  logic     reset,
   ptt_req_if.sink  req,
   ptt_rsp_if.source rsp
);
   localparam int unsigned IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int unsigned CntW = $clog2(NUM_SLOTS + 1);

   typedef struct packed {
      logic                                once;
      logic [ptt_pkg::HandlerWidth-1:0]    handler;
      logic [ptt_pkg::WordWidth-1:0]       key;
      logic [ptt_pkg::WordWidth-1:0]       pa;
      logic [ptt_pkg::WordWidth-1:0]       pb;
      logic [ptt_pkg::WordWidth-1:0]       pc;
      logic [ptt_pkg::WordWidth-1:0]       period;
      logic [ptt_pkg::TimeWidth-1:0]       expiry;
   } entry_type;

   entry_type mem [NUM_SLOTS];
   entry_type rd_ff;
   logic                 mem_we;
   logic [IdxW-1:0]      mem_addr;
   entry_type            mem_wd;

   logic [NUM_SLOTS-1:0] valid_ff, valid_in;
   ptt_pkg::state_type   state_ff, state_in;
   logic [CntW-1:0]      idx_ff, idx_in;
   logic [1:0]           op_ff, op_in;
   logic [ptt_pkg::TimeWidth-1:0] now_ff, now_in;
   logic [ptt_pkg::HandlerWidth-1:0] hid_ff, hid_in;
   logic [ptt_pkg::WordWidth-1:0] key_ff, key_in;

   logic                 ov_ff, ov_in, olast_ff, olast_in;
   logic [2:0]           okind_ff, okind_in;
   logic [ptt_pkg::SlotWidth-1:0] oslot_ff, oslot_in;
   entry_type            oent_ff, oent_in;

   logic                 free_hit;
   logic [IdxW-1:0]      free_idx;
   logic [IdxW-1:0]      cur;
   logic                 out_free;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wd;
      end
      rd_ff <= mem[mem_addr];
   end

   always_comb begin
      free_hit = 1'b0;
      free_idx = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_hit = 1'b1;
            free_idx = IdxW'(i);
         end
      end
   end

   assign cur = idx_ff[IdxW-1:0];
   assign out_free = !ov_ff || rsp.ready;
   assign req.ready = (state_ff == ptt_pkg::ST_IDLE) && !ov_ff;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      op_in    = op_ff;
      now_in   = now_ff;
      hid_in   = hid_ff;
      key_in   = key_ff;
      valid_in = valid_ff;
      ov_in    = ov_ff && !rsp.ready;
      okind_in = okind_ff;
      oslot_in = oslot_ff;
      olast_in = olast_ff;
      oent_in  = oent_ff;
      mem_we   = 1'b0;
      mem_addr = cur;
      mem_wd   = rd_ff;
      unique case (state_ff)
         ptt_pkg::ST_IDLE: begin
            if (req.valid && req.ready) begin
               op_in  = req.opcode;
               now_in = req.now_time;
               hid_in = req.handler_id;
               key_in = req.match_key;
               idx_in = '0;
               unique case (req.opcode)
                  ptt_pkg::OP_ADD: begin
                     ov_in = 1'b1;
                     olast_in = 1'b1;
                     oent_in = '0;
                     if (free_hit) begin
                        mem_we = 1'b1;
                        mem_addr = free_idx;
                        mem_wd.once = req.one_shot;
                        mem_wd.handler = req.handler_id;
                        mem_wd.key = req.match_key;
                        mem_wd.pa = req.payload_a;
                        mem_wd.pb = req.payload_b;
                        mem_wd.pc = req.payload_c;
                        mem_wd.period = req.period;
                        mem_wd.expiry = req.now_time + ptt_pkg::TimeWidth'(req.period);
                        valid_in[free_idx] = 1'b1;
                        okind_in = ptt_pkg::RK_ADDED;
                        oslot_in = ptt_pkg::SlotWidth'(free_idx);
                     end else begin
                        okind_in = ptt_pkg::RK_FULL;
                        oslot_in = '0;
                     end
                  end
                  ptt_pkg::OP_TICK, ptt_pkg::OP_DEL: begin
                     state_in = ptt_pkg::ST_READ;
                  end
                  default: ;
               endcase
            end
         end
         ptt_pkg::ST_READ: begin
            if (idx_ff == CntW'(NUM_SLOTS)) begin
               state_in = ptt_pkg::ST_FINAL;
            end else if (!valid_ff[cur]) begin
               idx_in = idx_ff + 1'b1;
            end else begin
               state_in = ptt_pkg::ST_EVAL;
            end
         end
         ptt_pkg::ST_EVAL: begin
            if (op_ff == ptt_pkg::OP_DEL) begin
               if (rd_ff.handler == hid_ff && rd_ff.key == key_ff) begin
                  if (out_free) begin
                     valid_in[cur] = 1'b0;
                     ov_in = 1'b1;
                     okind_in = ptt_pkg::RK_DELETED;
                     oslot_in = ptt_pkg::SlotWidth'(cur);
                     olast_in = 1'b1;
                     oent_in = '0;
                     state_in = ptt_pkg::ST_IDLE;
                  end
               end else begin
                  idx_in = idx_ff + 1'b1;
                  state_in = ptt_pkg::ST_READ;
               end
            end else if (rd_ff.expiry <= now_ff) begin
               mem_we = 1'b1;
               mem_wd.expiry = now_ff + ptt_pkg::TimeWidth'(rd_ff.period);
               state_in = ptt_pkg::ST_EMIT;
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = ptt_pkg::ST_READ;
            end
         end
         ptt_pkg::ST_EMIT: begin
            if (out_free) begin
               ov_in = 1'b1;
               okind_in = ptt_pkg::RK_FIRED;
               oslot_in = ptt_pkg::SlotWidth'(cur);
               olast_in = 1'b0;
               oent_in = rd_ff;
               if (rd_ff.once) begin
                  valid_in[cur] = 1'b0;
               end
               idx_in = idx_ff + 1'b1;
               state_in = ptt_pkg::ST_READ;
            end
         end
         ptt_pkg::ST_FINAL: begin
            if (out_free) begin
               ov_in = 1'b1;
               okind_in = (op_ff == ptt_pkg::OP_DEL) ? ptt_pkg::RK_NOT_FOUND
                                                     : ptt_pkg::RK_DONE;
               oslot_in = '0;
               olast_in = 1'b1;
               oent_in = '0;
               state_in = ptt_pkg::ST_IDLE;
            end
         end
         default: state_in = ptt_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptt_pkg::ST_IDLE;
         valid_ff <= '0;
         ov_ff    <= 1'b0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         ov_ff    <= ov_in;
         idx_ff   <= idx_in;
      end
      op_ff    <= op_in;
      now_ff   <= now_in;
      hid_ff   <= hid_in;
      key_ff   <= key_in;
      okind_ff <= okind_in;
      oslot_ff <= oslot_in;
      olast_ff <= olast_in;
      oent_ff  <= oent_in;
   end

   assign rsp.valid           = ov_ff;
   assign rsp.result_kind     = okind_ff;
   assign rsp.slot_index      = oslot_ff;
   assign rsp.fired_handler   = oent_ff.handler;
   assign rsp.fired_key       = oent_ff.key;
   assign rsp.fired_payload_a = oent_ff.pa;
   assign rsp.fired_payload_b = oent_ff.pb;
   assign rsp.fired_payload_c = oent_ff.pc;
   assign rsp.last            = olast_ff;

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |-> (state_ff == ptt_pkg::ST_IDLE))
      else $error("beat taken while busy");
   a_hold_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(okind_ff) && $stable(oslot_ff)))
      else $error("stalled beat changed");
   a_fire_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && okind_ff == ptt_pkg::RK_FIRED) |-> !olast_ff)
      else $error("fired beat marked last");
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= CntW'(NUM_SLOTS))
      else $error("walk index out of range");
`endif
endmodule
